// ===== rtl/sstla_pkg.sv =====
// ----------------------------------------------------------------------------
// sstla_pkg: shared types and constants of the scoped symbol table
// Store sizes, opcode and status codes, and the packed words of both channels.
// ----------------------------------------------------------------------------
package sstla_pkg;

  localparam int MaxNames  = 256;
  localparam int NameAw    = $clog2(MaxNames);
  localparam int CntW      = NameAw + 1;
  localparam int MaxLevels = 32;
  localparam int LevelAw   = $clog2(MaxLevels);
  localparam int ScopeW    = LevelAw + 1;
  localparam int SymBits   = 16;
  localparam int OpW       = 3;
  localparam int StatW     = 3;

  // Opcodes
  localparam logic [OpW-1:0] OpDefine     = 3'd0;
  localparam logic [OpW-1:0] OpDefineRaw  = 3'd1;
  localparam logic [OpW-1:0] OpEnter      = 3'd2;
  localparam logic [OpW-1:0] OpExit       = 3'd3;
  localparam logic [OpW-1:0] OpLookup     = 3'd4;
  localparam logic [OpW-1:0] OpCheckpoint = 3'd5;
  localparam logic [OpW-1:0] OpRollback   = 3'd6;

  // Status codes
  localparam logic [StatW-1:0] StOk        = 3'd0;
  localparam logic [StatW-1:0] StGlobals   = 3'd1;
  localparam logic [StatW-1:0] StFull      = 3'd2;
  localparam logic [StatW-1:0] StUnderflow = 3'd3;
  localparam logic [StatW-1:0] StDepth     = 3'd4;

  localparam logic [CntW-1:0] CapReset = CntW'(MaxNames);

  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic [SymBits-1:0] symbol_id;
  } in_word_t;

  typedef struct packed {
    logic [CntW-1:0]   offset;
    logic [ScopeW-1:0] scope;
    logic              found;
    logic [CntW-1:0]   cur_size;
    logic [StatW-1:0]  status;
  } out_word_t;

endpackage

// ===== rtl/scoped_symbol_table_lexical_address.sv =====
// ----------------------------------------------------------------------------
// scoped_symbol_table_lexical_address: scoped name table with lexical addresses
// Symbol ids of all frames share one name store; a level base RAM records
// where each nested frame begins. Commands define, enter, exit, look up,
// checkpoint and roll back; each gives exactly one result word.
// ----------------------------------------------------------------------------
// Define, enter, checkpoint, rollback and unknown opcodes answer straight from
// the idle state; exit, unless it underflows, also passes through SExit, as
// the base of the enclosing level comes from the level base RAM. A lookup
// examines names newest first and crosses enclosing levels: the name store's
// single read port delivers one entry per cycle within a level, and each level
// change reads the level base RAM in SScan and takes the base in, in SBase.
// busy_o is high while a command is in progress; each result shows on
// result_o for one cycle with valid_o and cannot be held off, and the next
// command may be started in that same cycle. Reset leaves an empty table at
// level 0 with global capacity 256; the global capacity is written through
// cfg_we_i.
module scoped_symbol_table_lexical_address
  import sstla_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  in_word_t        word_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i,
  output logic            valid_o,
  output out_word_t       result_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SBase = 2'd2;
  localparam logic [1:0] SExit = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    top_q, top_d;
  logic [LevelAw-1:0] level_q, level_d;
  logic [CntW-1:0]    base_q, base_d;
  logic [CntW-1:0]    saved_q, saved_d;
  logic [CntW-1:0]    cap_q;
  logic               res_valid_q, res_valid_d;
  logic               pend_q, pend_d;

  // Scan payload
  logic [CntW-1:0]    idx_q, idx_d;
  logic [LevelAw-1:0] lvl_q, lvl_d;
  logic [CntW-1:0]    scan_base_q, scan_base_d;
  logic [CntW-1:0]    pend_off_q, pend_off_d;
  logic [ScopeW-1:0]  pend_scope_q, pend_scope_d;
  logic [SymBits-1:0] sym_q, sym_d;
  logic [CntW-1:0]    exit_off_q, exit_off_d;
  out_word_t          res_q, res_d;

  // Memory ports
  logic               name_we;
  logic [NameAw-1:0]  name_waddr;
  logic [NameAw-1:0]  name_raddr;
  logic [SymBits-1:0] name_rdata;
  logic               lb_we;
  logic [LevelAw-1:0] lb_waddr;
  logic [LevelAw-1:0] lb_raddr;
  logic [CntW-1:0]    lb_rdata;

  logic               accept;
  logic [CntW-1:0]    frame;
  logic [CntW-1:0]    idx_m1;
  logic [CntW-1:0]    new_base;
  logic               hit;

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != SIdle);
  assign frame    = (top_q >= base_q) ? (top_q - base_q) : '0;
  assign idx_m1   = idx_q - CntW'(1);
  assign hit      = pend_q && (name_rdata == sym_q);
  assign new_base = (level_q == '0) ? '0 : lb_rdata;

  sstla_ram #(
    .Width (SymBits),
    .Depth (MaxNames)
  ) u_name_store (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_waddr),
    .wdata_i (word_i.symbol_id),
    .raddr_i (name_raddr),
    .rdata_o (name_rdata)
  );

  sstla_ram #(
    .Width (CntW),
    .Depth (MaxLevels)
  ) u_level_base (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (top_q),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  // Decode commands and advance the scan
  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    level_d      = level_q;
    base_d       = base_q;
    saved_d      = saved_q;
    res_valid_d  = 1'b0;
    pend_d       = pend_q;
    idx_d        = idx_q;
    lvl_d        = lvl_q;
    scan_base_d  = scan_base_q;
    pend_off_d   = pend_off_q;
    pend_scope_d = pend_scope_q;
    sym_d        = sym_q;
    exit_off_d   = exit_off_q;
    res_d        = res_q;
    name_we      = 1'b0;
    name_waddr   = top_q[NameAw-1:0];
    name_raddr   = idx_m1[NameAw-1:0];
    lb_we        = 1'b0;
    lb_waddr     = level_q + LevelAw'(1);
    lb_raddr     = level_q - LevelAw'(1);

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          res_d        = '0;
          res_d.cur_size = frame;
          res_valid_d  = 1'b1;
          unique case (word_i.opcode) inside
            OpDefine, OpDefineRaw: begin
              if (word_i.opcode == OpDefine && level_q == '0 && frame >= cap_q) begin
                res_d.status = StGlobals;
              end else if (top_q[CntW-1]) begin
                res_d.status = StFull;
              end else begin
                name_we          = 1'b1;
                top_d            = top_q + CntW'(1);
                res_d.offset     = frame + CntW'(1);
                res_d.cur_size   = frame + CntW'(1);
              end
            end
            OpEnter: begin
              if (level_q == LevelAw'(MaxLevels - 1)) begin
                res_d.status = StDepth;
              end else begin
                lb_we            = 1'b1;
                level_d          = level_q + LevelAw'(1);
                base_d           = top_q;
                res_d.cur_size   = '0;
              end
            end
            OpExit: begin
              if (level_q == '0) begin
                res_d.status = StUnderflow;
              end else begin
                // Fetch the enclosing base; the result is built in SExit and registered
                exit_off_d  = frame;
                top_d       = base_q;
                level_d     = level_q - LevelAw'(1);
                res_valid_d = 1'b0;
                state_d     = SExit;
              end
            end
            OpLookup: begin
              idx_d       = top_q;
              lvl_d       = level_q;
              scan_base_d = base_q;
              sym_d       = word_i.symbol_id;
              pend_d      = 1'b0;
              res_valid_d = 1'b0;
              state_d     = SScan;
            end
            OpCheckpoint: begin
              saved_d = frame;
            end
            OpRollback: begin
              top_d            = (saved_q > CntW'(MaxNames)) ? CntW'(MaxNames) : saved_q;
              level_d          = '0;
              base_d           = '0;
              res_d.cur_size   = top_d;
            end
            default: begin
            end
          endcase
        end
      end
      SExit: begin
        base_d           = new_base;
        res_d            = '0;
        res_d.offset     = exit_off_q;
        res_d.cur_size   = top_q - new_base;
        res_valid_d      = 1'b1;
        state_d          = SIdle;
      end
      SScan: begin
        res_d = '0;
        res_d.cur_size = frame;
        if (hit) begin
          res_d.found  = 1'b1;
          res_d.offset = pend_off_q;
          res_d.scope  = pend_scope_q;
          res_valid_d  = 1'b1;
          pend_d       = 1'b0;
          state_d      = SIdle;
        end else if (idx_q > scan_base_q) begin
          // Issue the next older entry; compare it next cycle
          pend_d       = 1'b1;
          pend_off_d   = idx_q - scan_base_q;
          pend_scope_d = (lvl_q == level_q) ? '0 : (ScopeW'(lvl_q) + ScopeW'(1));
          idx_d        = idx_m1;
        end else if (lvl_q == '0) begin
          res_valid_d = 1'b1;
          pend_d      = 1'b0;
          state_d     = SIdle;
        end else begin
          // Drop to the enclosing level and fetch its base
          lb_raddr = lvl_q - LevelAw'(1);
          lvl_d    = lvl_q - LevelAw'(1);
          pend_d   = 1'b0;
          state_d  = SBase;
        end
      end
      SBase: begin
        scan_base_d = (lvl_q == '0) ? '0 : lb_rdata;
        state_d     = SScan;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      top_q       <= '0;
      level_q     <= '0;
      base_q      <= '0;
      saved_q     <= '0;
      cap_q       <= CapReset;
      res_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      level_q     <= level_d;
      base_q      <= base_d;
      saved_q     <= saved_d;
      res_valid_q <= res_valid_d;
      pend_q      <= pend_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    lvl_q        <= lvl_d;
    scan_base_q  <= scan_base_d;
    pend_off_q   <= pend_off_d;
    pend_scope_q <= pend_scope_d;
    sym_q        <= sym_d;
    exit_off_q   <= exit_off_d;
    res_q        <= res_d;
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

// ===== rtl/sstla_ram.sv =====
// ----------------------------------------------------------------------------
// sstla_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sstla_ram #(
  parameter int Width = 16,
  parameter int Depth = 256,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read in the same clocked block
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sstla_checker.sv =====
// ----------------------------------------------------------------------------
// sstla_checker: port-level checks on the scoped symbol table
// Watches commands and result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module sstla_checker
  import sstla_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input in_word_t        word_i,
  input logic            cfg_we_i,
  input logic [CntW-1:0] cfg_data_i,
  input logic            valid_o,
  input out_word_t       result_o
);

  // Single-cycle commands answer in the next cycle
  a_quick_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && word_i.opcode != OpLookup && word_i.opcode != OpExit)
    |=> (valid_o && !busy_o))
    else $error("single-cycle command gave no word");

  // No word without a command behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result word without command");

  // A lookup occupies the block in the following cycle
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && word_i.opcode == OpLookup) |=> (busy_o && !valid_o))
    else $error("lookup did not hold busy");

  // A hit names a real position with status ok
  a_hit_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.found) |-> (result_o.offset != '0 && result_o.status == StOk))
    else $error("lookup hit with empty offset");

  // A configuration write never disturbs the busy flag of an idle block
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && !busy_o && !start_i) |=> !busy_o)
    else $error("configuration write started work");

endmodule

bind scoped_symbol_table_lexical_address sstla_checker u_sstla_checker (.*);

// ===== sim/scoped_symbol_table_lexical_address_check.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table answer check
// Watches the command and result channels of the block. It keeps its own copy
// of the name store, level bases, stack top, level and saved frame size, and
// works out the answer word of each accepted command. Result words are
// compared field by field against the oldest answer still owed.
// ----------------------------------------------------------------------------
module scoped_symbol_table_lexical_address_check
  import sstla_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  in_word_t        word_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i,
  input  logic            valid_i,
  input  out_word_t       result_i,
  output int              outstanding_o,
  output int              fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the table state
  logic [SymBits-1:0] names [MaxNames];
  logic [CntW-1:0]    bases [MaxLevels];
  logic [CntW-1:0]    top_idx;
  logic [ScopeW-1:0]  depth;
  logic [CntW-1:0]    saved_size;
  logic [CntW-1:0]    capacity;

  out_word_t answers_owed [$];
  int        fails = 0;

  // Level 0 always starts at the bottom of the store
  function automatic int base_at(int lvl);
    if (lvl == 0 || lvl >= MaxLevels) return 0;
    return int'(bases[LevelAw'(lvl)]);
  endfunction

  function automatic int frame_now();
    int b;
    b = base_at(int'(depth));
    return (int'(top_idx) >= b) ? int'(top_idx) - b : 0;
  endfunction

  // Apply one command to the mirror and build its answer word
  task automatic resolve_address(input in_word_t w, output out_word_t r);
    int  lvl;
    int  b;
    int  e;
    int  i;
    logic hit;
    r   = '0;
    hit = 1'b0;
    case (w.opcode) inside
      OpDefine, OpDefineRaw: begin
        if (w.opcode == OpDefine && depth == 0 && frame_now() >= int'(capacity)) begin
          r.status = StGlobals;
        end else if (int'(top_idx) >= MaxNames) begin
          r.status = StFull;
        end else begin
          names[top_idx[NameAw-1:0]] = w.symbol_id;
          top_idx++;
          r.offset = CntW'(frame_now());
        end
      end
      OpEnter: begin
        if (int'(depth) + 1 >= MaxLevels) begin
          r.status = StDepth;
        end else begin
          depth++;
          bases[depth[LevelAw-1:0]] = top_idx;
        end
      end
      OpExit: begin
        if (depth == 0) begin
          r.status = StUnderflow;
        end else begin
          r.offset = CntW'(frame_now());
          top_idx  = CntW'(base_at(int'(depth)));
          depth--;
        end
      end
      OpLookup: begin
        // Search newest first, current frame then each enclosing one
        lvl = int'(depth);
        forever begin
          b = base_at(lvl);
          e = (lvl == int'(depth)) ? int'(top_idx) : base_at(lvl + 1);
          if (e > MaxNames) e = MaxNames;
          for (i = e; i > b && !hit; i--) begin
            if (names[NameAw'(i-1)] == w.symbol_id) begin
              hit      = 1'b1;
              r.offset = CntW'(i - b);
              r.scope  = (lvl == int'(depth)) ? '0 : ScopeW'(lvl + 1);
            end
          end
          if (hit || lvl == 0) break;
          lvl--;
        end
        r.found = hit;
      end
      OpCheckpoint: begin
        saved_size = CntW'(frame_now());
      end
      OpRollback: begin
        top_idx = (int'(saved_size) > MaxNames) ? CntW'(MaxNames) : saved_size;
        depth   = '0;
      end
      default: begin
      end
    endcase
    r.cur_size = CntW'(frame_now());
  endtask

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endfunction

  // Track configuration, record answers on acceptance, check result words
  always @(posedge clk_i) begin
    out_word_t fresh;
    out_word_t want;
    if (!rst_ni) begin
      foreach (names[k]) names[k] = '0;
      foreach (bases[k]) bases[k] = '0;
      top_idx    = '0;
      depth      = '0;
      saved_size = '0;
      capacity   = CapReset;
      answers_owed.delete();
    end else begin
      if (cfg_we_i) capacity = cfg_data_i;
      if (start_i && !busy_i) begin
        resolve_address(word_i, fresh);
        answers_owed.push_back(fresh);
      end
      if (valid_i) begin
        if (answers_owed.size() == 0) begin
          $error("result word with no command outstanding");
          fails++;
        end else begin
          want = answers_owed.pop_front();
          compare_field("offset", int'(want.offset), int'(result_i.offset));
          compare_field("scope", int'(want.scope), int'(result_i.scope));
          compare_field("found", int'(want.found), int'(result_i.found));
          compare_field("cur_size", int'(want.cur_size), int'(result_i.cur_size));
          compare_field("status", int'(want.status), int'(result_i.status));
        end
      end
    end
    outstanding_o <= answers_owed.size();
    fails_o       <= fails;
  end

endmodule

// ===== sim/scoped_symbol_table_lexical_address_test.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table test bench
// Drives a short directed command sequence and then phases of weighted random
// commands under several global capacities, with random idle bursts on the
// command side. The answer check beside the block does all the comparing.
// ----------------------------------------------------------------------------
module scoped_symbol_table_lexical_address_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sstla_pkg::*;

  localparam logic [OpW-1:0] OpUnused   = 3'd7;
  localparam int             TailCycles = 300;
  localparam int             NumPhases  = 8;

  typedef enum {MixProfile, FillProfile, DeepProfile} profile_e;

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            start_i    = 1'b0;
  logic            busy_o;
  in_word_t        word_i     = '0;
  logic            cfg_we_i   = 1'b0;
  logic [CntW-1:0] cfg_data_i = '0;
  logic            valid_o;
  out_word_t       result_o;

  int outstanding;
  int fails;

  logic [SymBits-1:0] recent_syms [$];
  bit                 idle_on    = 1'b1;
  int                 quiet_left = 0;

  profile_e plan [NumPhases] = '{MixProfile, MixProfile, FillProfile, DeepProfile,
                                 MixProfile, FillProfile, DeepProfile, MixProfile};

  scoped_symbol_table_lexical_address uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .word_i     (word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

  scoped_symbol_table_lexical_address_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .word_i        (word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .valid_i       (valid_o),
    .result_i      (result_o),
    .outstanding_o (outstanding),
    .fails_o       (fails)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("FAIL scoped_symbol_table_lexical_address");
    $finish;
  end

  // Hold off until every answer is back and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy_o);
  endtask

  task automatic set_capacity(input logic [CntW-1:0] cap);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Send one command word, with an optional idle burst in front of it
  task automatic issue(input logic [OpW-1:0] op, input logic [SymBits-1:0] sym);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end else if (idle_on && $urandom_range(0, 39) == 0) begin
      quiet_left = $urandom_range(20, 60);
    end
    start_i <= 1'b1;
    word_i  <= '{opcode: op, symbol_id: sym};
    do @(posedge clk_i); while (busy_o);
    if (op == OpDefine || op == OpDefineRaw) begin
      recent_syms.push_back(sym);
      if (recent_syms.size() > 48) void'(recent_syms.pop_front());
    end
  endtask

  // Mostly names already defined, so lookups hit and defines shadow
  function automatic logic [SymBits-1:0] draw_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && recent_syms.size() > 0)
      return recent_syms[$urandom_range(0, recent_syms.size() - 1)];
    if (r < 80) return SymBits'($urandom_range(0, 15));
    return SymBits'($urandom);
  endfunction

  function automatic logic [OpW-1:0] draw_opcode(profile_e p);
    int w [8];
    int total;
    int r;
    case (p)
      FillProfile: begin
        w[OpDefine] = 25; w[OpDefineRaw] = 45; w[OpEnter] = 4; w[OpExit] = 3;
        w[OpLookup] = 20; w[OpCheckpoint] = 1; w[OpRollback] = 1; w[OpUnused] = 1;
      end
      DeepProfile: begin
        w[OpDefine] = 20; w[OpDefineRaw] = 10; w[OpEnter] = 30; w[OpExit] = 12;
        w[OpLookup] = 22; w[OpCheckpoint] = 3; w[OpRollback] = 2; w[OpUnused] = 1;
      end
      default: begin
        w[OpDefine] = 28; w[OpDefineRaw] = 10; w[OpEnter] = 10; w[OpExit] = 10;
        w[OpLookup] = 32; w[OpCheckpoint] = 4; w[OpRollback] = 3; w[OpUnused] = 3;
      end
    endcase
    total = 0;
    foreach (w[k]) total += w[k];
    r = $urandom_range(0, total - 1);
    foreach (w[k]) begin
      if (r < w[k]) return OpW'(k);
      r -= w[k];
    end
    return OpLookup;
  endfunction

  initial begin
    int cap;
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: shadowing, enclosing hits, misses, underflow, nested checkpoint
    issue(OpDefine, 16'h0000);
    issue(OpDefine, 16'hFFFF);
    issue(OpLookup, 16'hFFFF);
    issue(OpLookup, 16'h1234);
    issue(OpEnter, 16'h0000);
    issue(OpDefineRaw, 16'h0000);
    issue(OpDefine, 16'hABCD);
    issue(OpLookup, 16'h0000);
    issue(OpLookup, 16'hFFFF);
    issue(OpCheckpoint, 16'h0000);
    issue(OpEnter, 16'hFFFF);
    issue(OpLookup, 16'hABCD);
    issue(OpExit, 16'h0000);
    issue(OpExit, 16'h0000);
    issue(OpExit, 16'h0000);
    issue(OpUnused, 16'hFFFF);
    issue(OpRollback, 16'h0000);
    issue(OpLookup, 16'hFFFF);

    // Directed: global limit against the unchecked define
    set_capacity(CntW'(2));
    issue(OpDefine, 16'h5555);
    issue(OpDefineRaw, 16'h5555);
    issue(OpEnter, 16'h0000);
    issue(OpDefine, 16'h7777);
    issue(OpLookup, 16'h5555);
    issue(OpExit, 16'h0000);
    issue(OpCheckpoint, 16'h0000);
    issue(OpRollback, 16'h0000);

    // Random phases, each under its own capacity; no idling in the last one
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       cap = 1;
        2, 4:    cap = 256;
        6:       cap = 255;
        default: cap = $urandom_range(1, 256);
      endcase
      set_capacity(CntW'(cap));
      idle_on    = (p != NumPhases - 1);
      quiet_left = 0;
      n = 180;
      if (plan[p] == FillProfile) begin
        // Push past the store depth so the full case is reached
        repeat (MaxNames + 4) issue(OpDefineRaw, draw_symbol());
        n = 120;
      end else if (plan[p] == DeepProfile) begin
        // Nest one level past the limit
        repeat (MaxLevels) issue(OpEnter, draw_symbol());
        n = 190;
      end
      repeat (n) begin
        if (idle_on && $urandom_range(0, 99) == 0) drain();
        issue(draw_opcode(plan[p]), draw_symbol());
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS scoped_symbol_table_lexical_address");
    end else begin
      $display("FAIL scoped_symbol_table_lexical_address");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sstla_pkg.sv
rtl/sstla_ram.sv
rtl/scoped_symbol_table_lexical_address.sv
rtl/sstla_checker.sv
sim/scoped_symbol_table_lexical_address_check.sv
sim/scoped_symbol_table_lexical_address_test.sv
